@@ design/otq_pkg.sv @@
// ----------------------------------------------------------------------------
// otq_pkg
// shared opcodes, controller state encoding and control structs
// ----------------------------------------------------------------------------
package otq_pkg;

	localparam int OP_W = 2;

	typedef enum logic [OP_W-1:0] {
		OP_ADD   = 2'd0,
		OP_DEL   = 2'd1,
		OP_CHECK = 2'd2,
		OP_SLEEP = 2'd3
	} opcode_t;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SCAN  = 5'b00010,
		ST_EXEC  = 5'b00100,
		ST_OUT   = 5'b01000,
		ST_SPARE = 5'b10000
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic scan_start;
		logic scan_step;
		logic exec;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_last;
	} dp_sts_t;

endpackage

@@ design/otq_if.sv @@
// ----------------------------------------------------------------------------
// otq_if
// valid/ready channel carrying a generic payload
// ----------------------------------------------------------------------------
interface otq_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ design/otq_ctrl.sv @@
// ----------------------------------------------------------------------------
// otq_ctrl
// sequencer: load item, scan the table one slot per cycle, update, deliver
// ----------------------------------------------------------------------------
module otq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output otq_pkg::dp_cmd_t cmd,
	input  otq_pkg::dp_sts_t sts
);
	import otq_pkg::*;

	state_t state_q;
	state_t state_d;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);

	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load       = 1'b1;
					cmd.scan_start = 1'b1;
					state_d        = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_last) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = ST_OUT;
			end
			ST_OUT: begin
				if (out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end
endmodule

@@ design/otq_dp.sv @@
// ----------------------------------------------------------------------------
// otq_dp
// timer table, sequential scan for earliest / match / free slot, result regs
// ----------------------------------------------------------------------------
module otq_dp #(
	parameter int CAPACITY   = 16,
	parameter int TIME_WIDTH = 48,
	parameter int ID_WIDTH   = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  otq_pkg::dp_cmd_t      cmd,
	output otq_pkg::dp_sts_t      sts,
	input  logic [1:0]            opcode,
	input  logic [TIME_WIDTH-1:0] now_ms,
	input  logic [31:0]           delay_ms,
	input  logic [ID_WIDTH-1:0]   target_id,
	input  logic [TIME_WIDTH-1:0] target_expiry,
	output logic                  op_ok,
	output logic [ID_WIDTH-1:0]   timer_id,
	output logic [TIME_WIDTH-1:0] expiry_ms,
	output logic                  queue_empty,
	output logic [TIME_WIDTH-1:0] sleep_ms
);
	import otq_pkg::*;

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	// wide enough for the larger operand plus a carry
	localparam int SW = ((TIME_WIDTH > 32) ? TIME_WIDTH : 32) + 1;
	localparam logic [SW-1:0] TMAX = SW'({TIME_WIDTH{1'b1}});

	logic [CAPACITY-1:0]   valid_q;
	logic [TIME_WIDTH-1:0] exp_q [CAPACITY];
	logic [ID_WIDTH-1:0]   id_q [CAPACITY];
	logic [ID_WIDTH-1:0]   next_id_q;

	opcode_t               op_q;
	logic [TIME_WIDTH-1:0] now_q;
	logic [ID_WIDTH-1:0]   key_id_q;
	logic [TIME_WIDTH-1:0] key_exp_q;

	logic [IW-1:0]         idx_q;
	logic                  best_vld_q;
	logic [IW-1:0]         best_q;
	logic [TIME_WIDTH-1:0] best_exp_q;
	logic [ID_WIDTH-1:0]   best_id_q;
	logic                  match_vld_q;
	logic [IW-1:0]         match_q;
	logic                  free_vld_q;
	logic [IW-1:0]         free_q;

	logic [SW-1:0]         sum;
	logic [TIME_WIDTH-1:0] sat_sum;
	logic [TIME_WIDTH-1:0] cur_exp;
	logic [ID_WIDTH-1:0]   cur_id;
	logic                  cur_vld;
	logic                  better;
	logic                  hit;

	// saturating expiry for add
	assign sum     = SW'(now_ms) + SW'(delay_ms);
	assign sat_sum = (sum > TMAX) ? {TIME_WIDTH{1'b1}} : sum[TIME_WIDTH-1:0];

	assign cur_exp = exp_q[idx_q];
	assign cur_id  = id_q[idx_q];
	assign cur_vld = valid_q[idx_q];
	assign better  = cur_vld && (!best_vld_q || cur_exp < best_exp_q ||
		(cur_exp == best_exp_q && cur_id < best_id_q));
	assign hit     = cur_vld && cur_id == key_id_q && cur_exp == key_exp_q;

	assign sts.scan_last = (32'(idx_q) == CAPACITY - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			next_id_q <= '0;
		end else if (cmd.load && opcode_t'(opcode) == OP_ADD) begin
			next_id_q <= next_id_q + 1'b1;
		end else if (cmd.exec) begin
			case (op_q)
				OP_ADD:   if (!match_vld_q && free_vld_q) valid_q[free_q] <= 1'b1;
				OP_DEL:   if (match_vld_q) valid_q[match_q] <= 1'b0;
				OP_CHECK: if (best_vld_q && best_exp_q <= now_q) valid_q[best_q] <= 1'b0;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && op_q == OP_ADD && !match_vld_q && free_vld_q) begin
			exp_q[free_q] <= key_exp_q;
			id_q[free_q]  <= key_id_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= opcode_t'(opcode);
			now_q <= now_ms;
			if (opcode_t'(opcode) == OP_ADD) begin
				key_id_q  <= next_id_q;
				key_exp_q <= sat_sum;
			end else begin
				key_id_q  <= target_id;
				key_exp_q <= target_expiry;
			end
		end
		if (cmd.scan_start) begin
			idx_q       <= '0;
			best_vld_q  <= 1'b0;
			match_vld_q <= 1'b0;
			free_vld_q  <= 1'b0;
		end else if (cmd.scan_step) begin
			idx_q <= idx_q + 1'b1;
			if (better) begin
				best_vld_q <= 1'b1;
				best_q     <= idx_q;
				best_exp_q <= cur_exp;
				best_id_q  <= cur_id;
			end
			if (hit && !match_vld_q) begin
				match_vld_q <= 1'b1;
				match_q     <= idx_q;
			end
			if (!cur_vld && !free_vld_q) begin
				free_vld_q <= 1'b1;
				free_q     <= idx_q;
			end
		end
		if (cmd.exec) begin
			op_ok       <= 1'b0;
			timer_id    <= '0;
			expiry_ms   <= '0;
			queue_empty <= 1'b0;
			sleep_ms    <= '0;
			case (op_q)
				OP_ADD: begin
					op_ok     <= !match_vld_q && free_vld_q;
					timer_id  <= key_id_q;
					expiry_ms <= key_exp_q;
				end
				OP_DEL: op_ok <= match_vld_q;
				OP_CHECK: begin
					if (best_vld_q && best_exp_q <= now_q) begin
						op_ok     <= 1'b1;
						timer_id  <= best_id_q;
						expiry_ms <= best_exp_q;
					end
				end
				OP_SLEEP: begin
					if (!best_vld_q) queue_empty <= 1'b1;
					else if (best_exp_q > now_q) sleep_ms <= best_exp_q - now_q;
				end
				default: ;
			endcase
		end
	end
endmodule

@@ design/ordered_timer_queue.sv @@
// ----------------------------------------------------------------------------
// ordered_timer_queue
// table of pending timers ordered by expiry then id: add, delete, check, sleep
//
//  channel  dir  payload
//  in_ch    in   opcode, now_ms, delay_ms, target_id, target_expiry
//  out_ch   out  op_ok, timer_id, expiry_ms, queue_empty, sleep_ms
//
//  each item goes through load, one table slot scanned per cycle for
//  earliest, matching and free entries, update, then delivery.
//  reset clears the valid bits and the id counter; no clearing pass.
//  a stalled result holds the block; the next item is taken after delivery.
// ----------------------------------------------------------------------------
module ordered_timer_queue #(
	parameter int CAPACITY   = 16,
	parameter int TIME_WIDTH = 48,
	parameter int ID_WIDTH   = 32
) (
	input logic clk,
	input logic arst_n,
	otq_if.sink   in_ch,
	otq_if.source out_ch
);
	import otq_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	otq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	otq_dp #(
		.CAPACITY   (CAPACITY),
		.TIME_WIDTH (TIME_WIDTH),
		.ID_WIDTH   (ID_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.opcode        (in_ch.data.opcode),
		.now_ms        (in_ch.data.now_ms),
		.delay_ms      (in_ch.data.delay_ms),
		.target_id     (in_ch.data.target_id),
		.target_expiry (in_ch.data.target_expiry),
		.op_ok         (out_ch.data.op_ok),
		.timer_id      (out_ch.data.timer_id),
		.expiry_ms     (out_ch.data.expiry_ms),
		.queue_empty   (out_ch.data.queue_empty),
		.sleep_ms      (out_ch.data.sleep_ms)
	);
endmodule

@@ tb/tb_otq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_otq_pkg
// item layouts of the timer queue channels as seen by the testbench
// ----------------------------------------------------------------------------
package tb_otq_pkg;

	import otq_pkg::*;

	typedef struct packed {
		opcode_t     opcode;
		logic [47:0] now_ms;
		logic [31:0] delay_ms;
		logic [31:0] target_id;
		logic [47:0] target_expiry;
	} timer_cmd_t;

	typedef struct packed {
		logic        op_ok;
		logic [31:0] timer_id;
		logic [47:0] expiry_ms;
		logic        queue_empty;
		logic [47:0] sleep_ms;
	} timer_rsp_t;

endpackage

@@ tb/otq_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otq_checker
// watches both channels, keeps a shadow timer table and compares every result
// ----------------------------------------------------------------------------
module otq_checker
	import otq_pkg::*;
	import tb_otq_pkg::*;
#(
	parameter int SLOTS = 16
) (
	input  logic   clk,
	input  logic   arst_n,
	otq_if         cmd_ch,
	otq_if         rsp_ch,
	output int     errors,
	output int     pending,
	output int     n_fired,
	output int     n_full,
	output int     n_del_hit
);

	localparam logic [47:0] TIME_MAX = '1;

	logic        slot_used [SLOTS];
	logic [47:0] slot_exp [SLOTS];
	logic [31:0] slot_id [SLOTS];
	logic [31:0] id_counter;
	timer_rsp_t  rsp_due [$];

	assign pending = rsp_due.size();

	// index of the earliest pending timer, -1 if none
	function automatic int earliest_slot();
		int best;
		best = -1;
		for (int i = 0; i < SLOTS; i++) begin
			if (!slot_used[i])
				continue;
			if (best < 0 || slot_exp[i] < slot_exp[best] ||
			    (slot_exp[i] == slot_exp[best] && slot_id[i] < slot_id[best]))
				best = i;
		end
		return best;
	endfunction

	function automatic int find_timer(logic [31:0] id, logic [47:0] xp);
		for (int i = 0; i < SLOTS; i++)
			if (slot_used[i] && slot_id[i] == id && slot_exp[i] == xp)
				return i;
		return -1;
	endfunction

	task automatic apply_cmd(timer_cmd_t c);
		timer_rsp_t  r;
		logic [48:0] sum;
		int          k;
		r = '0;
		case (c.opcode)
			OP_ADD: begin
				sum = {1'b0, c.now_ms} + {17'b0, c.delay_ms};
				r.timer_id = id_counter;
				r.expiry_ms = sum[48] ? TIME_MAX : sum[47:0];
				id_counter = id_counter + 1;
				if (find_timer(r.timer_id, r.expiry_ms) < 0) begin
					for (k = 0; k < SLOTS; k++) begin
						if (!slot_used[k]) begin
							slot_used[k] = 1'b1;
							slot_id[k] = r.timer_id;
							slot_exp[k] = r.expiry_ms;
							r.op_ok = 1'b1;
							break;
						end
					end
				end
				if (!r.op_ok)
					n_full++;
			end
			OP_DEL: begin
				k = find_timer(c.target_id, c.target_expiry);
				if (k >= 0) begin
					slot_used[k] = 1'b0;
					r.op_ok = 1'b1;
					n_del_hit++;
				end
			end
			OP_CHECK: begin
				k = earliest_slot();
				if (k >= 0 && slot_exp[k] <= c.now_ms) begin
					r.op_ok = 1'b1;
					r.timer_id = slot_id[k];
					r.expiry_ms = slot_exp[k];
					slot_used[k] = 1'b0;
					n_fired++;
				end
			end
			default: begin
				k = earliest_slot();
				if (k < 0)
					r.queue_empty = 1'b1;
				else if (slot_exp[k] > c.now_ms)
					r.sleep_ms = slot_exp[k] - c.now_ms;
			end
		endcase
		rsp_due.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		timer_rsp_t want;
		timer_rsp_t got;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++)
				slot_used[i] = 1'b0;
			id_counter = '0;
			rsp_due.delete();
			errors = 0;
			n_fired = 0;
			n_full = 0;
			n_del_hit = 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got = rsp_ch.data;
				if (rsp_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected result %p", $time, got);
				end else begin
					want = rsp_due.pop_front();
					if (got.op_ok !== want.op_ok || got.timer_id !== want.timer_id ||
					    got.expiry_ms !== want.expiry_ms ||
					    got.queue_empty !== want.queue_empty ||
					    got.sleep_ms !== want.sleep_ms) begin
						errors++;
						$display("%0t: mismatch expected %p actual %p", $time, want, got);
					end
				end
			end
			if (cmd_ch.valid && cmd_ch.ready)
				apply_cmd(cmd_ch.data);
		end
	end

endmodule

@@ tb/tb_ordered_timer_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ordered_timer_queue
// directed and random timer commands with random stalls on both channels;
// results are checked by otq_checker against a shadow timer table
// ----------------------------------------------------------------------------
module tb_ordered_timer_queue;

	import otq_pkg::*;
	import tb_otq_pkg::*;

	localparam int SLOTS = 16;
	localparam int N_RANDOM = 400;
	localparam int STALL_LIMIT = 3000;
	localparam int LONG_HOLD = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	otq_if #(.payload_t(timer_cmd_t)) cmd_ch ();
	otq_if #(.payload_t(timer_rsp_t)) rsp_ch ();

	int errors, pending, n_fired, n_full, n_del_hit;
	int stall_cycles = 0;
	int n_sent = 0;
	bit idle_on = 1'b1;
	bit long_hold = 1'b0;

	logic [47:0] clock_ms = '0;
	logic [31:0] issued_id [$];
	logic [47:0] issued_exp [$];
	logic [31:0] add_count = '0;

	ordered_timer_queue #(.CAPACITY(SLOTS), .TIME_WIDTH(48), .ID_WIDTH(32)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (cmd_ch),
		.out_ch (rsp_ch)
	);

	otq_checker #(.SLOTS(SLOTS)) i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_ch    (cmd_ch),
		.rsp_ch    (rsp_ch),
		.errors    (errors),
		.pending   (pending),
		.n_fired   (n_fired),
		.n_full    (n_full),
		.n_del_hit (n_del_hit)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			stall_cycles <= 0;
		else if (arst_n)
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("tb_ordered_timer_queue: errors");
			$finish;
		end
	end

	// result side: random stall bursts and one long hold-off on request
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold) begin
				rsp_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				long_hold = 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 17) - 1) @(negedge clk);
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	task automatic push(timer_cmd_t c);
		logic [48:0] sum;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			cmd_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.data <= c;
		do @(posedge clk); while (!cmd_ch.ready);
		// remember what was added so later deletes can hit
		if (c.opcode == OP_ADD) begin
			sum = {1'b0, c.now_ms} + {17'b0, c.delay_ms};
			issued_id.push_back(add_count);
			issued_exp.push_back(sum[48] ? 48'hFFFF_FFFF_FFFF : sum[47:0]);
			add_count++;
		end
		n_sent++;
		@(negedge clk);
	endtask

	function automatic timer_cmd_t mk(opcode_t op, logic [47:0] now, logic [31:0] dly,
		logic [31:0] tid, logic [47:0] texp);
		timer_cmd_t c;
		c.opcode = op;
		c.now_ms = now;
		c.delay_ms = dly;
		c.target_id = tid;
		c.target_expiry = texp;
		return c;
	endfunction

	function automatic logic [47:0] rand48();
		return 48'({$urandom, $urandom});
	endfunction

	task automatic random_cmd(bit wild);
		timer_cmd_t c;
		int         k;
		c = mk(opcode_t'($urandom_range(0, 3)), clock_ms, $urandom_range(0, 60),
			$urandom, rand48());
		clock_ms = clock_ms + 48'($urandom_range(0, 8));
		if (wild) begin
			c.now_ms = rand48();
			c.delay_ms = $urandom;
		end
		if (c.opcode == OP_DEL && issued_id.size() > 0 && $urandom_range(0, 3) != 0) begin
			k = $urandom_range(0, issued_id.size() - 1);
			c.target_id = issued_id[k];
			c.target_expiry = issued_exp[k];
		end
		// keep checks frequent enough that the table drains
		if (c.opcode == OP_SLEEP && $urandom_range(0, 1) == 0)
			c.opcode = OP_CHECK;
		push(c);
	endtask

	initial begin
		cmd_ch.valid = 1'b0;
		cmd_ch.data = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty table, saturating adds, exact delete, miss, expiry edges
		push(mk(OP_SLEEP, 48'd0, 32'd0, 32'd0, 48'd0));
		push(mk(OP_CHECK, 48'hFFFF_FFFF_FFFF, 32'd0, 32'd0, 48'd0));
		push(mk(OP_ADD, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'd0));
		push(mk(OP_ADD, 48'hFFFF_0000_0000, 32'hFFFF_FFFF, 32'd0, 48'hFFFF_FFFF_FFFF));
		push(mk(OP_ADD, 48'd100, 32'd0, 32'd0, 48'd0));
		push(mk(OP_ADD, 48'd90, 32'd10, 32'd0, 48'd0));
		push(mk(OP_SLEEP, 48'd40, 32'd0, 32'd0, 48'd0));
		push(mk(OP_SLEEP, 48'd500, 32'd0, 32'd0, 48'd0));
		push(mk(OP_CHECK, 48'd99, 32'd0, 32'd0, 48'd0));
		push(mk(OP_DEL, 48'd0, 32'd0, 32'd3, 48'd101));
		push(mk(OP_DEL, 48'd0, 32'd0, 32'd3, 48'd100));
		push(mk(OP_CHECK, 48'd100, 32'd0, 32'd0, 48'd0));
		push(mk(OP_DEL, 48'd0, 32'd0, 32'd0, 48'hFFFF_FFFF_FFFF));
		push(mk(OP_DEL, 48'd0, 32'd0, 32'd0, 48'hFFFF_FFFF_FFFF));
		// fill the table and go one past full
		for (int i = 0; i < SLOTS; i++)
			push(mk(OP_ADD, 48'd200, $urandom_range(0, 3), 32'd0, 48'd0));

		// let results back up while commands keep coming
		long_hold = 1'b1;
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM - 60)
				idle_on = 1'b0;
			random_cmd($urandom_range(0, 15) == 0);
		end
		// drain whatever is left so the table is seen empty again
		for (int i = 0; i < SLOTS + 2; i++)
			push(mk(OP_CHECK, 48'hFFFF_FFFF_FFFF, 32'd0, 32'd0, 48'd0));
		push(mk(OP_SLEEP, 48'd0, 32'd0, 32'd0, 48'd0));
		cmd_ch.valid <= 1'b0;

		wait (pending == 0);
		repeat (40) @(posedge clk);
		$display("covered %0d commands: %0d timers fired, %0d deletes hit, %0d adds refused",
			n_sent, n_fired, n_del_hit, n_full);
		if (errors == 0)
			$display("tb_ordered_timer_queue: clean");
		else
			$display("tb_ordered_timer_queue: errors");
		$finish;
	end

endmodule
